@@ rtl/bgm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bgm_pkg
// Shared types, widths and helpers for the pixel background model update unit.
// ----------------------------------------------------------------------------
package bgm_pkg;

    localparam int PIXELS      = 16384;
    localparam int ADDR_W      = $clog2(PIXELS);
    localparam int IDX_W       = 14;
    localparam int L_W         = 11;
    localparam int C_W         = 12;
    localparam int CNT_W       = 16;
    localparam int THR_W       = 8;
    localparam int THR_SQ_W    = 24;
    localparam int DIST_W      = 26;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int THR_RESET   = 25;
    localparam int LIMIT_RESET = 100;

    // input tdata layout
    localparam int IN_TDATA_W = 56;
    localparam int IN_L_LSB   = IDX_W;
    localparam int IN_A_LSB   = IN_L_LSB + L_W;
    localparam int IN_B_LSB   = IN_A_LSB + C_W;

    // output tdata layout
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_CNT_LSB = L_W + 2 * C_W;
    localparam int OUT_CNT_MSB = OUT_CNT_LSB + CNT_W - 1;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (OUT_CNT_MSB + 1);

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_LOAD   = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_THRESHOLD = 1'b0,
        CFG_PROMOTE_LIMIT   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic        [L_W-1:0] l;
        logic signed [C_W-1:0] a;
        logic signed [C_W-1:0] b;
    } t_lab;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        t_lab              px;
    } t_item;

    typedef struct packed {
        t_lab             bg;
        t_lab             cand;
        logic [CNT_W-1:0] cnt;
    } t_entry;

    typedef struct packed {
        logic [CNT_W-1:0]    promote_limit;
        logic [THR_SQ_W-1:0] thr_sq;
    } t_cfg;

    typedef struct packed {
        logic s2_valid;
        logic hazard;
        logic wr_en;
    } t_back_stat;

    function automatic logic [L_W-1:0] avg_l(logic [L_W-1:0] x, logic [L_W-1:0] y);
        logic [L_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[L_W:1];
    endfunction

    function automatic logic signed [C_W-1:0] avg_c(logic signed [C_W-1:0] x,
                                                    logic signed [C_W-1:0] y);
        logic signed [C_W:0] s;
        s = $signed({x[C_W-1], x}) + $signed({y[C_W-1], y});
        return s[C_W:1];
    endfunction

    function automatic t_lab avg_lab(t_lab p, t_lab q);
        t_lab r;
        r.l = avg_l(p.l, q.l);
        r.a = avg_c(p.a, q.a);
        r.b = avg_c(p.b, q.b);
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/bgm_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bgm_front
// Input stage: accepts pixels, decodes the request kind, holds config registers.
// ----------------------------------------------------------------------------
module bgm_front (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // pixel_index, pixel_l, pixel_a, pixel_b, zero pad
    input  wire  [bgm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // first_frame
    input  wire  [0:0]                        s_axis_tuser,
    input  wire                               i_cfg_we,
    input  wire  [bgm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [bgm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_item_valid,
    input  wire                               i_item_ready,
    output bgm_pkg::t_item                    o_item,
    output bgm_pkg::t_cfg                     o_cfg
);

    logic                           r_valid;
    bgm_pkg::t_item                 r_item;
    bgm_pkg::t_item                 n_item;
    logic [bgm_pkg::THR_W-1:0]      r_match_threshold;
    logic [bgm_pkg::CNT_W-1:0]      r_promote_limit;
    logic [bgm_pkg::THR_SQ_W-1:0]   r_thr_sq;
    logic [2*bgm_pkg::THR_W-1:0]    w_thr_prod;

    assign s_axis_tready = !r_valid || i_item_ready;

    always_comb begin
        n_item.op   = s_axis_tuser[0] ? bgm_pkg::OP_LOAD : bgm_pkg::OP_UPDATE;
        n_item.addr = s_axis_tdata[bgm_pkg::ADDR_W-1:0];
        n_item.px.l = s_axis_tdata[bgm_pkg::IN_L_LSB +: bgm_pkg::L_W];
        n_item.px.a = s_axis_tdata[bgm_pkg::IN_A_LSB +: bgm_pkg::C_W];
        n_item.px.b = s_axis_tdata[bgm_pkg::IN_B_LSB +: bgm_pkg::C_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item <= n_item;
        end
    end

    // (thr * 16)^2 = thr^2 << 8
    assign w_thr_prod = r_match_threshold * r_match_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_threshold <= bgm_pkg::THR_W'(bgm_pkg::THR_RESET);
            r_promote_limit   <= bgm_pkg::CNT_W'(bgm_pkg::LIMIT_RESET);
            r_thr_sq          <= bgm_pkg::THR_SQ_W'(bgm_pkg::THR_RESET * bgm_pkg::THR_RESET * 256);
        end else begin
            r_thr_sq <= {w_thr_prod, 8'd0};
            if (i_cfg_we) begin
                unique case (bgm_pkg::t_cfg_idx'(i_cfg_index))
                    bgm_pkg::CFG_MATCH_THRESHOLD: begin
                        r_match_threshold <= i_cfg_data[bgm_pkg::THR_W-1:0];
                    end
                    bgm_pkg::CFG_PROMOTE_LIMIT: begin
                        r_promote_limit <= i_cfg_data[bgm_pkg::CNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_item_valid        = r_valid;
    assign o_item              = r_item;
    assign o_cfg.promote_limit = r_promote_limit;
    assign o_cfg.thr_sq        = r_thr_sq;

endmodule
`default_nettype wire

@@ rtl/bgm_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bgm_queue
// Small request queue between front and back ends.
// ----------------------------------------------------------------------------
module bgm_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push_valid,
    output logic            o_push_ready,
    input  bgm_pkg::t_item  i_push_item,
    output logic            o_pop_valid,
    input  wire             i_pop_ready,
    output bgm_pkg::t_item  o_pop_item
);

    bgm_pkg::t_item                 r_slot [bgm_pkg::QUEUE_DEPTH];
    logic [bgm_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [bgm_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [bgm_pkg::QCNT_W-1:0]     r_count;
    logic                           w_push;
    logic                           w_pop;

    assign o_push_ready = r_count != bgm_pkg::QCNT_W'(bgm_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_item   = r_slot[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    function automatic logic [bgm_pkg::QPTR_W-1:0] ptr_next(logic [bgm_pkg::QPTR_W-1:0] p);
        return (p == bgm_pkg::QPTR_W'(bgm_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

endmodule
`default_nettype wire

@@ rtl/bgm_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bgm_back
// Back end: per-pixel store read, distance, update rule, write-back, output.
// ----------------------------------------------------------------------------
module bgm_back (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_item_valid,
    output logic                              o_item_ready,
    input  bgm_pkg::t_item                    i_item,
    input  bgm_pkg::t_cfg                     i_cfg,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // bg_l, bg_a, bg_b, stable_count, zero pad
    output logic [bgm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // is_foreground
    output logic [0:0]                        m_axis_tuser,
    output bgm_pkg::t_back_stat               o_stat
);

    localparam int DL_W   = bgm_pkg::L_W + 1;
    localparam int DC_W   = bgm_pkg::C_W + 1;
    localparam int SQL_W  = 2 * bgm_pkg::L_W;
    localparam int SQC_W  = 2 * bgm_pkg::C_W;

    bgm_pkg::t_entry                r_mem [bgm_pkg::PIXELS];
    bgm_pkg::t_entry                r_rd;

    logic                           r_s1_v;
    bgm_pkg::t_item                 r_s1;
    logic                           r_wb_v;
    logic [bgm_pkg::ADDR_W-1:0]     r_wb_addr;
    bgm_pkg::t_entry                r_wb;

    logic                           r_s2_v;
    bgm_pkg::t_item                 r_s2;
    bgm_pkg::t_entry                r_s2_old;
    logic [SQL_W-1:0]               r_dl2;
    logic [SQC_W-1:0]               r_da2;
    logic [SQC_W-1:0]               r_db2;

    logic                           r_o_v;
    logic [bgm_pkg::OUT_TDATA_W-1:0] r_o_tdata;
    logic                           r_o_fg;

    logic                           w_hazard;
    logic                           w_s1_load;
    logic                           w_s1_adv;
    logic                           w_s2_load;
    logic                           w_s2_adv;
    logic                           w_o_load;
    bgm_pkg::t_entry                w_old;
    logic signed [DL_W-1:0]         w_dl;
    logic signed [DC_W-1:0]         w_da;
    logic signed [DC_W-1:0]         w_db;
    logic signed [2*DL_W-1:0]       w_dl_sq;
    logic signed [2*DC_W-1:0]       w_da_sq;
    logic signed [2*DC_W-1:0]       w_db_sq;
    logic [bgm_pkg::DIST_W-1:0]     w_dist;
    logic                           w_near;
    bgm_pkg::t_entry                w_new;
    logic                           w_fg;

    // pipeline control
    assign w_o_load  = !r_o_v || m_axis_tready;
    assign w_s2_adv  = r_s2_v && w_o_load;
    assign w_s2_load = !r_s2_v || w_s2_adv;
    // same pixel one stage ahead: wait for its write-back
    assign w_hazard  = r_s1_v && r_s2_v && (r_s2.addr == r_s1.addr);
    assign w_s1_adv  = r_s1_v && !w_hazard && w_s2_load;
    assign w_s1_load = !r_s1_v || w_s1_adv;

    assign o_item_ready = w_s1_load;

    always_ff @(posedge i_clk) begin
        if (w_s2_adv) begin
            r_mem[r_s2.addr] <= w_new;
        end
        if (w_s1_load) begin
            r_rd <= r_mem[i_item.addr];
        end
    end

    // stage 1: forward last write, squared differences
    assign w_old = (r_wb_v && (r_wb_addr == r_s1.addr)) ? r_wb : r_rd;

    always_comb begin
        w_dl    = $signed({1'b0, r_s1.px.l}) - $signed({1'b0, w_old.bg.l});
        w_da    = $signed({r_s1.px.a[bgm_pkg::C_W-1], r_s1.px.a})
                - $signed({w_old.bg.a[bgm_pkg::C_W-1], w_old.bg.a});
        w_db    = $signed({r_s1.px.b[bgm_pkg::C_W-1], r_s1.px.b})
                - $signed({w_old.bg.b[bgm_pkg::C_W-1], w_old.bg.b});
        w_dl_sq = w_dl * w_dl;
        w_da_sq = w_da * w_da;
        w_db_sq = w_db * w_db;
    end

    // stage 2: distance compare and update rule
    assign w_dist = bgm_pkg::DIST_W'(r_dl2) + bgm_pkg::DIST_W'(r_da2)
                  + bgm_pkg::DIST_W'(r_db2);
    assign w_near = w_dist < bgm_pkg::DIST_W'(i_cfg.thr_sq);

    always_comb begin
        w_new = r_s2_old;
        w_fg  = 1'b0;
        unique case (r_s2.op)
            bgm_pkg::OP_LOAD: begin
                w_new.bg   = r_s2.px;
                w_new.cand = r_s2.px;
                w_new.cnt  = '0;
            end
            bgm_pkg::OP_UPDATE: begin
                if (w_near) begin
                    if (r_s2_old.cnt == '0) begin
                        w_new.cand = r_s2.px;
                    end else if (r_s2_old.cnt < i_cfg.promote_limit) begin
                        w_new.cand = bgm_pkg::avg_lab(r_s2.px, r_s2_old.cand);
                    end else begin
                        w_new.bg = r_s2_old.cand;
                    end
                    if (r_s2_old.cnt != '1) begin
                        w_new.cnt = r_s2_old.cnt + 1'b1;
                    end
                end else begin
                    w_new.bg  = bgm_pkg::avg_lab(r_s2.px, r_s2_old.bg);
                    w_new.cnt = '0;
                    w_fg      = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_o_v  <= 1'b0;
            r_wb_v <= 1'b0;
        end else begin
            if (w_s1_load) begin
                r_s1_v <= i_item_valid;
            end
            if (w_s2_load) begin
                r_s2_v <= w_s1_adv;
            end
            if (w_o_load) begin
                r_o_v <= r_s2_v;
            end
            if (w_s2_adv) begin
                r_wb_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load && i_item_valid) begin
            r_s1 <= i_item;
        end
        if (w_s1_adv) begin
            r_s2     <= r_s1;
            r_s2_old <= w_old;
            r_dl2    <= w_dl_sq[SQL_W-1:0];
            r_da2    <= w_da_sq[SQC_W-1:0];
            r_db2    <= w_db_sq[SQC_W-1:0];
        end
        if (w_s2_adv) begin
            r_wb_addr <= r_s2.addr;
            r_wb      <= w_new;
            r_o_tdata <= {{bgm_pkg::OUT_PAD_W{1'b0}}, w_new.cnt,
                          w_new.bg.b, w_new.bg.a, w_new.bg.l};
            r_o_fg    <= w_fg;
        end
    end

    assign m_axis_tvalid   = r_o_v;
    assign m_axis_tdata    = r_o_tdata;
    assign m_axis_tuser[0] = r_o_fg;

    assign o_stat.s2_valid = r_s2_v;
    assign o_stat.hazard   = w_hazard;
    assign o_stat.wr_en    = w_s2_adv;

endmodule
`default_nettype wire

@@ rtl/pixel_background_model_update_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_background_model_update_unit
// Per-pixel running-average background model with candidate promotion.
// ----------------------------------------------------------------------------
// Pipeline: input reg, queue, store read, multiply, update + output reg.
// Throughput: 1 pixel/cycle without output stalls; a bubble when two pixels
//   in a row share an address (read-modify-write loop through the store).
// Reset: synchronous, clears control state and config to defaults; store
//   contents are undefined until written, no clearing pass.
module pixel_background_model_update_unit (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // pixel_index[13:0], pixel_l[24:14], pixel_a[36:25], pixel_b[48:37], pad
    input  wire  [bgm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // first_frame[0]
    input  wire  [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // bg_l[10:0], bg_a[22:11], bg_b[34:23], stable_count[50:35], pad
    output logic [bgm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // is_foreground[0]
    output logic [0:0]                        m_axis_tuser,
    input  wire                               i_cfg_we,
    input  wire  [bgm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [bgm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic                   w_front_valid;
    logic                   w_front_ready;
    bgm_pkg::t_item         w_front_item;
    bgm_pkg::t_cfg          w_cfg;
    logic                   w_q_valid;
    logic                   w_q_ready;
    bgm_pkg::t_item         w_q_item;
    bgm_pkg::t_back_stat    w_stat;

    bgm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_item_valid  (w_front_valid),
        .i_item_ready  (w_front_ready),
        .o_item        (w_front_item),
        .o_cfg         (w_cfg)
    );

    bgm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_item  (w_front_item),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_item   (w_q_item)
    );

    bgm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (w_q_valid),
        .o_item_ready  (w_q_ready),
        .i_item        (w_q_item),
        .i_cfg         (w_cfg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_stat        (w_stat)
    );

    // a stalled same-address pixel clears once its predecessor writes back
    a_hazard_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.hazard && w_stat.wr_en |=> !w_stat.hazard)
        else $error("address hazard persisted after write-back");

    // foreground results always carry a cleared count
    a_fg_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[bgm_pkg::OUT_CNT_MSB:bgm_pkg::OUT_CNT_LSB] == '0))
        else $error("foreground result with nonzero count");

    // every new result comes with a store write-back
    a_out_has_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_stat.wr_en && w_stat.s2_valid))
        else $error("result without store write-back");

endmodule
`default_nettype wire

@@ test/pixel_background_model_update_unit_tb.sv @@
// ----------------------------------------------------------------------------
// pixel_background_model_update_unit_tb
// Self-checking bench for the per-pixel background model update unit. A
// directed set covers the field extremes, the threshold edge, loads,
// promotion and the zero settings. Random pixel sequences then run around a
// few home colours under several register settings. A behavioral model of
// the stores predicts every result. Most settings idle both sides at random.
// ----------------------------------------------------------------------------
module pixel_background_model_update_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bgm_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int WD_LIMIT    = 4000;
    localparam int MAX_REPORTS = 30;

    typedef struct {
        logic [IDX_W-1:0]      idx;
        logic [L_W-1:0]        l;
        logic signed [C_W-1:0] a;
        logic signed [C_W-1:0] b;
        t_op                   op;
    } t_pixel_req;

    typedef struct {
        t_lab             bg;
        logic [CNT_W-1:0] cnt;
        logic             fg;
    } t_bg_result;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    pixel_background_model_update_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // model of the per-pixel stores and registers
    t_lab             model_bg   [PIXELS];
    t_lab             model_cand [PIXELS];
    logic [CNT_W-1:0] model_cnt  [PIXELS];
    logic [THR_W-1:0] cfg_thr    = THR_W'(THR_RESET);
    logic [CNT_W-1:0] cfg_limit  = CNT_W'(LIMIT_RESET);

    bit               addr_seen  [PIXELS];
    t_pixel_req       pend_q[$];
    t_bg_result       expect_q[$];
    t_pixel_req       cur_req;

    int  n_queued, n_accepted, n_checked, n_errors, n_settings;
    int  n_load, n_fg, n_promote, n_sat;
    int  gap_left, stall_left, hold_left, wd_count;
    bit  idle_on, held_once;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic t_lab lab_mean(t_lab p, t_lab q);
        t_lab r;
        int   s;
        s   = int'(p.l) + int'(q.l);
        r.l = L_W'(s >>> 1);
        s   = int'($signed(p.a)) + int'($signed(q.a));
        r.a = C_W'(s >>> 1);
        s   = int'($signed(p.b)) + int'($signed(q.b));
        r.b = C_W'(s >>> 1);
        return r;
    endfunction

    function automatic t_bg_result update_model(t_pixel_req r);
        t_lab             px, bgc, cnd;
        logic [CNT_W-1:0] c;
        longint           dl, da, db, lim;
        t_bg_result       res;
        px.l   = r.l;
        px.a   = r.a;
        px.b   = r.b;
        res.fg = 1'b0;
        if (r.op == OP_LOAD) begin
            model_bg[r.idx]   = px;
            model_cand[r.idx] = px;
            model_cnt[r.idx]  = '0;
            n_load++;
        end else begin
            bgc = model_bg[r.idx];
            cnd = model_cand[r.idx];
            c   = model_cnt[r.idx];
            dl  = longint'(px.l) - longint'(bgc.l);
            da  = longint'($signed(px.a)) - longint'($signed(bgc.a));
            db  = longint'($signed(px.b)) - longint'($signed(bgc.b));
            lim = longint'(cfg_thr) * 16;
            if (dl * dl + da * da + db * db < lim * lim) begin
                if (c == '0) begin
                    model_cand[r.idx] = px;
                end else if (c < cfg_limit) begin
                    model_cand[r.idx] = lab_mean(px, cnd);
                end else begin
                    model_bg[r.idx] = cnd;
                    n_promote++;
                end
                if (c != '1) begin
                    c++;
                end else begin
                    n_sat++;
                end
                model_cnt[r.idx] = c;
            end else begin
                model_bg[r.idx]  = lab_mean(px, bgc);
                model_cnt[r.idx] = '0;
                res.fg           = 1'b1;
                n_fg++;
            end
        end
        res.bg  = model_bg[r.idx];
        res.cnt = model_cnt[r.idx];
        return res;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endtask

    // an address never loaded is always sent as a load
    task automatic push_req(int idx, int l, int a, int b, t_op op);
        t_pixel_req r;
        r.idx = IDX_W'(idx);
        r.l   = L_W'(l);
        r.a   = C_W'(a);
        r.b   = C_W'(b);
        r.op  = addr_seen[r.idx] ? op : OP_LOAD;
        addr_seen[r.idx] = 1'b1;
        pend_q.push_back(r);
        n_queued++;
    endtask

    task automatic drain();
        while (n_accepted != n_queued || expect_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx which, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (which == CFG_MATCH_THRESHOLD) cfg_thr = val[THR_W-1:0];
        else cfg_limit = val;
    endtask

    task automatic set_phase(int thr, int limit, bit idle);
        drain();
        cfg_write(CFG_MATCH_THRESHOLD, CFG_DATA_W'(thr));
        cfg_write(CFG_PROMOTE_LIMIT, CFG_DATA_W'(limit));
        idle_on = idle;
        n_settings++;
    endtask

    // sequences around a few home colours, with jumps, reloads and noise
    task automatic random_phase(int n_items);
        int   pool [6];
        int   home_l [6], home_a [6], home_b [6];
        int   k, sel, r, mag, idx, l, a, b;
        t_op  op;
        for (k = 0; k < 6; k++) begin
            pool[k]   = $urandom_range(0, PIXELS - 1);
            home_l[k] = $urandom_range(0, 1600);
            home_a[k] = $urandom_range(0, 4095) - 2048;
            home_b[k] = $urandom_range(0, 4095) - 2048;
        end
        for (k = 0; k < n_items; k++) begin
            sel = $urandom_range(0, 5);
            r   = $urandom_range(0, 99);
            op  = ($urandom_range(0, 99) < 5) ? OP_LOAD : OP_UPDATE;
            idx = pool[sel];
            if (r < 10) begin
                idx = $urandom_range(0, PIXELS - 1);
                l   = $urandom_range(0, 2047);
                a   = $urandom_range(0, 4095) - 2048;
                b   = $urandom_range(0, 4095) - 2048;
            end else if (r < 22) begin
                l = $urandom_range(0, 1600);
                a = $urandom_range(0, 4095) - 2048;
                b = $urandom_range(0, 4095) - 2048;
                if (r < 16) begin
                    home_l[sel] = l;
                    home_a[sel] = a;
                    home_b[sel] = b;
                end
            end else if (r < 30) begin
                l = home_l[sel];
                a = home_a[sel];
                b = home_b[sel];
            end else begin
                mag = int'(cfg_thr) * $urandom_range(4, 12) + 2;
                l = clip(home_l[sel] + $urandom_range(0, 2 * mag) - mag, 0, 2047);
                a = clip(home_a[sel] + $urandom_range(0, 2 * mag) - mag, -2048, 2047);
                b = clip(home_b[sel] + $urandom_range(0, 2 * mag) - mag, -2048, 2047);
            end
            push_req(idx, l, a, b, op);
        end
    endtask

    // request side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                expect_q.push_back(update_model(cur_req));
                n_accepted++;
            end
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                cur_req = pend_q.pop_front();
                s_axis_tdata  <= {7'd0, cur_req.b, cur_req.a, cur_req.l, cur_req.idx};
                s_axis_tuser  <= cur_req.op;
                s_axis_tvalid <= 1'b1;
                gap_left = idle_on ? rand_gap() : 0;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge i_clk) begin
        t_bg_result want;
        logic       rdy;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expect_q.size() == 0) begin
                    n_errors++;
                    $error("result with nothing expected");
                end else begin
                    want = expect_q.pop_front();
                    check_field("bg_l", want.bg.l, m_axis_tdata[10:0]);
                    check_field("bg_a", $signed(want.bg.a), $signed(m_axis_tdata[22:11]));
                    check_field("bg_b", $signed(want.bg.b), $signed(m_axis_tdata[34:23]));
                    check_field("stable_count", want.cnt, m_axis_tdata[50:35]);
                    check_field("is_foreground", want.fg, m_axis_tuser[0]);
                end
                n_checked++;
            end
            // one long hold-off so the pipe backs up into the input
            if (!held_once && n_checked >= 150) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0) stall_left = rand_gap();
            end
            m_axis_tready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            wd_count <= 0;
        end else if (wd_count >= WD_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            wd_count <= wd_count + 1;
        end
    end

    initial begin
        idle_on = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        n_settings = 1;

        // reset settings: extremes, threshold edge, load then near
        push_req(0, 0, -2048, -2048, OP_LOAD);
        push_req(16383, 2047, 2047, 2047, OP_LOAD);
        push_req(0, 0, -2047, -2048, OP_UPDATE);
        push_req(0, 3, -2045, -2047, OP_UPDATE);
        push_req(16383, 0, -2048, -2048, OP_UPDATE);
        push_req(5, 800, 0, 0, OP_LOAD);
        push_req(5, 1200, 0, 0, OP_UPDATE);
        push_req(6, 800, 0, 0, OP_LOAD);
        push_req(6, 1199, 0, 0, OP_UPDATE);
        push_req(7, 0, 2047, -2048, OP_LOAD);
        push_req(7, 1600, -2048, 2047, OP_UPDATE);

        // promote after a single match
        set_phase(255, 1, 1'b1);
        push_req(8, 500, 100, -100, OP_LOAD);
        push_req(8, 510, 90, -90, OP_UPDATE);
        push_req(8, 520, -50, 50, OP_UPDATE);
        push_req(8, 520, -50, 50, OP_UPDATE);

        // zero promote limit
        set_phase(255, 0, 1'b1);
        push_req(9, 700, 5, 5, OP_LOAD);
        push_req(9, 701, 6, 4, OP_UPDATE);
        push_req(9, 702, 7, 3, OP_UPDATE);

        // zero threshold: even an identical pixel is foreground
        set_phase(0, 0, 1'b1);
        push_req(9, 701, 6, 4, OP_UPDATE);

        set_phase(25, 100, 1'b1);
        random_phase(300);
        set_phase(255, 65535, 1'b0);
        random_phase(300);
        set_phase(8, 3, 1'b1);
        random_phase(300);
        set_phase(0, 1, 1'b1);
        random_phase(300);
        set_phase(40, 0, 1'b1);
        random_phase(300);
        set_phase(16, 7, 1'b0);
        random_phase(300);
        drain();

        $display("covered %0d requests over %0d settings, %0d results checked",
                 n_accepted, n_settings, n_checked);
        $display("loads %0d, foreground %0d, promotions %0d, saturated %0d, mismatches %0d",
                 n_load, n_fg, n_promote, n_sat, n_errors);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
